>>> rtl/wmc_pkg.sv
// Shared types and constants for the wildcard match counter.
package wmc_pkg;

  localparam int SYM_W   = 5;
  localparam int COUNT_W = 32;

  // Operation field codes on the input channel
  localparam logic OP_PATTERN = 1'b0;
  localparam logic OP_TEXT    = 1'b1;

  // Symbol code for the pattern wildcard
  localparam logic [SYM_W-1:0] WILDCARD_CODE = 5'd26;

  // Queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef enum logic [1:0] {
    CMD_PATTERN,
    CMD_TEXT,
    CMD_TEXT_LAST
  } cmd_t;

  typedef enum logic [1:0] {
    SYM_LETTER,
    SYM_WILD,
    SYM_OTHER
  } sym_cls_t;

  typedef struct packed {
    cmd_t             cmd;
    sym_cls_t         cls;
    logic [SYM_W-1:0] sym;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_push_t;

endpackage

>>> rtl/wmc_in_if.sv
// Input channel: pattern symbols and text letters.
interface wmc_in_if;
  logic                      valid;
  logic                      ready;
  logic                      operation;
  logic [wmc_pkg::SYM_W-1:0] symbol;
  logic                      last;

  modport source (output valid, output operation, output symbol, output last, input ready);
  modport sink   (input valid, input operation, input symbol, input last, output ready);
endinterface

>>> rtl/wmc_out_if.sv
// Result channel: match count and pattern overflow flag.
interface wmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [wmc_pkg::COUNT_W-1:0] match_count;
  logic                        pattern_overflow;

  modport source (output valid, output match_count, output pattern_overflow, input ready);
  modport sink   (input valid, input match_count, input pattern_overflow, output ready);
endinterface

>>> rtl/wildcard_match_counter_core.sv
// Top level of the wildcard match counter: front end, queue and match engine.
//
//   channel  direction  handshake        payload
//   in_ch    in         valid / ready    operation, symbol, last
//   out_ch   out        valid / ready    match_count, pattern_overflow
//
// Throughput is one item per cycle unless a final text letter waits on a held result;
// the match engine's shift-and step (mask row read, shift, and, count update) is
// combinational. A final text letter passes the queue, then loads the result register.
// Reset is synchronous, no clearing pass; queue entries and result payload are not reset.
// A two-entry queue absorbs stalls; only a final text letter waits on a full
// result register, other items keep executing while a result is held.
module wildcard_match_counter_core #(
  parameter int MAX_PATTERN   = 64,
  parameter int ALPHABET_SIZE = 26
) (
  input logic       clk,
  input logic       rst_n,
  wmc_in_if.sink    in_ch,
  wmc_out_if.source out_ch
);
  import wmc_pkg::*;

  q_push_t q_push;
  logic    q_full;
  logic    q_valid;
  item_t   q_item;
  logic    q_pop;

  wmc_front #(
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .push_o (q_push)
  );

  wmc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (q_push),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  wmc_back #(
    .ALPHABET_SIZE (ALPHABET_SIZE),
    .MAX_PATTERN   (MAX_PATTERN)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

>>> rtl/wmc_front.sv
// Front end: accepts input items, classifies them and pushes them into the queue.
module wmc_front #(
  parameter int ALPHABET_SIZE = 26
) (
  wmc_in_if.sink            in_ch,
  input  logic              q_full,
  output wmc_pkg::q_push_t  push_o
);
  import wmc_pkg::*;

  sym_cls_t cls;
  cmd_t     cmd;

  // Accept whenever the queue has room
  assign in_ch.ready = !q_full;

  // Classify the symbol
  always_comb begin
    if (in_ch.symbol < SYM_W'(ALPHABET_SIZE)) begin
      cls = SYM_LETTER;
    end else if (in_ch.symbol == WILDCARD_CODE) begin
      cls = SYM_WILD;
    end else begin
      cls = SYM_OTHER;
    end
  end

  // Decode the operation; last only matters on text
  always_comb begin
    if (in_ch.operation == OP_PATTERN) begin
      cmd = CMD_PATTERN;
    end else if (in_ch.last) begin
      cmd = CMD_TEXT_LAST;
    end else begin
      cmd = CMD_TEXT;
    end
  end

  assign push_o.push     = in_ch.valid && !q_full;
  assign push_o.item.cmd = cmd;
  assign push_o.item.cls = cls;
  assign push_o.item.sym = in_ch.symbol;

endmodule

>>> rtl/wmc_fifo.sv
// Two-entry queue between the front end and the match engine.
module wmc_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  wmc_pkg::q_push_t push_i,
  output logic             full_o,
  output logic             valid_o,
  output wmc_pkg::item_t   item_o,
  input  logic             pop_i
);
  import wmc_pkg::*;

  item_t              entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] cnt_r;
  logic               do_pop;

  assign full_o  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign valid_o = (cnt_r != '0);
  assign item_o  = entries_r[rd_ptr_r];
  assign do_pop  = pop_i && valid_o;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push_i.push) begin
      entries_r[wr_ptr_r] <= push_i.item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push_i.push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push_i.push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push_i.push && do_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/wmc_back.sv
// Match engine: shift-and over per-letter masks, counter and result register.
module wmc_back #(
  parameter int ALPHABET_SIZE = 26,
  parameter int MAX_PATTERN   = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  wmc_pkg::item_t q_item,
  output logic           q_pop,
  wmc_out_if.source      out_ch
);
  import wmc_pkg::*;

  localparam int LTR_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;

  logic [MAX_PATTERN-1:0] masks_r   [ALPHABET_SIZE];
  logic [MAX_PATTERN-1:0] masks_nxt [ALPHABET_SIZE];
  logic [MAX_PATTERN-1:0] top_r, top_nxt;       // one-hot of last pattern position
  logic [MAX_PATTERN-1:0] active_r, active_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic                   ovf_r, ovf_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   out_free;
  logic [LTR_W-1:0]       ltr_idx;
  logic [MAX_PATTERN-1:0] new_bit;
  logic [MAX_PATTERN-1:0] text_mask;
  logic [MAX_PATTERN-1:0] act_step;
  logic                   hit;
  logic [COUNT_W-1:0]     count_step;

  assign out_free = !out_valid_r || out_ch.ready;
  assign q_pop    = q_valid && ((q_item.cmd != CMD_TEXT_LAST) || out_free);
  assign ltr_idx  = q_item.sym[LTR_W-1:0];

  // Next free pattern position
  assign new_bit = (top_r == '0) ? MAX_PATTERN'(1) : (top_r << 1);

  // One shift-and step for a text letter
  assign text_mask  = (q_item.cls == SYM_LETTER) ? masks_r[ltr_idx] : '0;
  assign act_step   = ((active_r << 1) | MAX_PATTERN'(1)) & text_mask;
  assign hit        = |(act_step & top_r);
  assign count_step = (hit && (count_r != '1)) ? (count_r + 1'b1) : count_r;

  // Execute the popped item
  always_comb begin
    masks_nxt     = masks_r;
    top_nxt       = top_r;
    active_nxt    = active_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_count_nxt = out_count_r;
    out_ovf_nxt   = out_ovf_r;
    if (q_pop) begin
      case (q_item.cmd)
        CMD_PATTERN: begin
          if (top_r[MAX_PATTERN-1]) begin
            ovf_nxt = 1'b1;
          end else begin
            top_nxt = new_bit;
            case (q_item.cls)
              SYM_LETTER: masks_nxt[ltr_idx] = masks_r[ltr_idx] | new_bit;
              SYM_WILD: begin
                for (int r = 0; r < ALPHABET_SIZE; r++) begin
                  masks_nxt[r] = masks_r[r] | new_bit;
                end
              end
              default: ;
            endcase
          end
        end
        CMD_TEXT: begin
          active_nxt = act_step;
          count_nxt  = count_step;
        end
        CMD_TEXT_LAST: begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_step;
          out_ovf_nxt   = ovf_r;
          masks_nxt     = '{default: '0};
          top_nxt       = '0;
          active_nxt    = '0;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Hold engine state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      masks_r     <= '{default: '0};
      top_r       <= '0;
      active_r    <= '0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      masks_r     <= masks_nxt;
      top_r       <= top_nxt;
      active_r    <= active_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_count_r <= out_count_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.match_count      = out_count_r;
  assign out_ch.pattern_overflow = out_ovf_r;

`ifndef ASSERT_OFF
  a_top_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(top_r))
    else $error("pattern end marker is not one-hot");

  a_no_prefix_without_pattern: assert property (@(posedge clk) disable iff (!rst_n)
    (top_r == '0) |-> (active_r == '0))
    else $error("active prefixes with an empty pattern");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && (q_item.cmd == CMD_TEXT_LAST)) |=> (out_valid_r && (count_r == '0)))
    else $error("final letter did not load a result and clear the count");
`endif

endmodule
